// ===== rtl/nearest_point_to_ray_unit_defines.svh =====
// Assertion macros for the nearest point to ray unit
`ifndef NEAREST_POINT_TO_RAY_UNIT_DEFINES_SVH
`define NEAREST_POINT_TO_RAY_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define NPR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NPR_ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        vld && !rdy |=> vld && $stable(sig)) else $error(msg);
`else
`define NPR_ASSERT(label, clk, rst_n, prop, msg)
`define NPR_ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig, msg)
`endif
`endif

// ===== rtl/npr_pkg.sv =====
// Shared types and constants for the nearest point to ray unit
`timescale 1ns / 1ps
package npr_pkg;
    localparam int COORD_W = 12;
    localparam int MAX_POINTS_DEF = 65536;
    localparam int IDX_W = 16;
    localparam int DIST_W = 13;
    localparam int CSQ_W = 56;
    localparam int DSQ_W = 25;
    localparam int CFG_IDX_W = 3;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 3'd5;

    typedef struct packed {
        logic [IDX_W-1:0] closest_index;
        logic [CSQ_W-1:0] best;
        logic [DSQ_W-1:0] dsq;
    } job_t;
endpackage

// ===== rtl/npr_if.sv =====
// Valid/ready channel interfaces
`timescale 1ns / 1ps
interface npr_point_if;
    logic valid;
    logic ready;
    logic [11:0] point_x;
    logic [11:0] point_y;
    logic [11:0] point_z;
    logic last_point;
    modport source (output valid, point_x, point_y, point_z, last_point, input ready);
    modport sink (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface npr_result_if;
    logic valid;
    logic ready;
    logic [15:0] closest_index;
    logic [12:0] closest_distance;
    logic degenerate_ray;
    modport source (output valid, closest_index, closest_distance, degenerate_ray,
        input ready);
    modport sink (input valid, closest_index, closest_distance, degenerate_ray,
        output ready);
endinterface

interface npr_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [11:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/npr_front.sv =====
// Front part: cross product, running minimum and list tracking
`timescale 1ns / 1ps
module npr_front
    import npr_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_W
)(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [COORD_W-1:0] point_x,
    input  logic [COORD_W-1:0] point_y,
    input  logic [COORD_W-1:0] point_z,
    input  logic last_point,
    input  logic [COORD_W-1:0] cfg_reg [6],
    output logic job_valid,
    input  logic job_ready,
    output job_t job
);
    localparam int CNT_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    function automatic logic signed [13:0] sx(input logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] m;
        m = v;
        for (int i = COORD_BITS; i < COORD_W; i++) m[i] = v[COORD_BITS-1];
        return 14'(signed'(m));
    endfunction

    logic s1_valid_reg, s1_last_reg;
    logic signed [13:0] px_reg, py_reg, pz_reg;
    logic signed [13:0] dx_reg, dy_reg, dz_reg;
    logic s2_valid_reg, s2_last_reg;
    logic signed [27:0] m_reg [6];
    logic signed [28:0] cx_reg, cy_reg, cz_reg;
    logic s3_valid_reg, s3_last_reg;
    logic [CSQ_W-1:0] csq_next;
    logic [DSQ_W-1:0] dsq_next, dsq_reg;
    logic [CSQ_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] cnt_reg, cnt1_reg, cnt2_reg, cnt3_reg;
    logic [IDX_W-1:0] cnt_idx;
    logic signed [13:0] dxs, dys, dzs;
    logic stall;

    assign stall = s3_valid_reg && s3_last_reg && !job_ready;
    assign in_ready = !stall;
    assign dxs = sx(cfg_reg[3]);
    assign dys = sx(cfg_reg[4]);
    assign dzs = sx(cfg_reg[5]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            cnt_reg <= '0;
            best_reg <= '1;
            pos_reg <= '0;
        end
        else if (!stall)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (in_valid)
                cnt_reg <= (last_point || cnt_reg == CNT_W'(MAX_POINTS - 1)) ? '0 :
                    cnt_reg + 1'b1;
            if (s3_valid_reg && s3_last_reg)
            begin
                best_reg <= '1;
                pos_reg <= '0;
            end
            else if (s3_valid_reg)
            begin
                best_reg <= best_next;
                pos_reg <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            s1_last_reg <= last_point;
            cnt1_reg <= cnt_reg;
            px_reg <= sx(point_x) - sx(cfg_reg[0]);
            py_reg <= sx(point_y) - sx(cfg_reg[1]);
            pz_reg <= sx(point_z) - sx(cfg_reg[2]);
            dx_reg <= dxs;
            dy_reg <= dys;
            dz_reg <= dzs;
            cnt2_reg <= cnt1_reg;
            s2_last_reg <= s1_last_reg;
            m_reg[0] <= py_reg * dz_reg;
            m_reg[1] <= pz_reg * dy_reg;
            m_reg[2] <= pz_reg * dx_reg;
            m_reg[3] <= px_reg * dz_reg;
            m_reg[4] <= px_reg * dy_reg;
            m_reg[5] <= py_reg * dx_reg;
            dsq_reg <= DSQ_W'(dx_reg * dx_reg) + DSQ_W'(dy_reg * dy_reg)
                + DSQ_W'(dz_reg * dz_reg);
            cnt3_reg <= cnt2_reg;
            s3_last_reg <= s2_last_reg;
            cx_reg <= 29'(m_reg[0]) - 29'(m_reg[1]);
            cy_reg <= 29'(m_reg[2]) - 29'(m_reg[3]);
            cz_reg <= 29'(m_reg[4]) - 29'(m_reg[5]);
        end
    end

    assign dsq_next = dsq_reg;
    assign csq_next = CSQ_W'(unsigned'(58'(cx_reg * cx_reg)))
        + CSQ_W'(unsigned'(58'(cy_reg * cy_reg)))
        + CSQ_W'(unsigned'(58'(cz_reg * cz_reg)));
    assign cnt_idx = IDX_W'(cnt3_reg);

    always_comb
    begin
        best_next = best_reg;
        pos_next = pos_reg;
        if (csq_next < best_reg)
        begin
            best_next = csq_next;
            pos_next = cnt_idx;
        end
    end

    assign job_valid = s3_valid_reg && s3_last_reg;
    assign job.closest_index = pos_next;
    assign job.best = best_next;
    assign job.dsq = dsq_next;
endmodule

// ===== rtl/npr_back.sv =====
// Back part: queue, divide and square root to the result register
`timescale 1ns / 1ps
module npr_back
    import npr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    output logic job_ready,
    input  job_t job,
    output logic res_valid,
    input  logic res_ready,
    output logic [IDX_W-1:0] closest_index,
    output logic [DIST_W-1:0] closest_distance,
    output logic degenerate_ray
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_OUT = 3'd3;

    job_t q_reg [2];
    logic [1:0] q_cnt_reg;
    logic q_rd_reg, q_wr_reg;
    logic [2:0] state_reg;
    logic [5:0] step_reg;
    logic [CSQ_W-1:0] quo_reg;
    logic [DSQ_W:0] rem_reg;
    logic [DSQ_W-1:0] d_reg;
    logic [DSQ_W:0] rem_sh;
    logic [DIST_W-1:0] root_reg, trial;
    logic [2*DIST_W-1:0] trial_sq;
    logic [IDX_W-1:0] idx_reg;
    logic push, pop;
    job_t head;

    assign job_ready = q_cnt_reg != 2'd2;
    assign push = job_valid && job_ready;
    assign pop = state_reg == ST_IDLE && q_cnt_reg != 2'd0;
    assign head = q_reg[q_rd_reg];
    assign rem_sh = {rem_reg[DSQ_W-1:0], quo_reg[CSQ_W-1]};
    assign trial = root_reg | (DIST_W'(1) << step_reg[3:0]);
    assign trial_sq = trial * trial;

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[q_wr_reg] <= job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg <= '0;
            q_rd_reg <= 1'b0;
            q_wr_reg <= 1'b0;
            state_reg <= ST_IDLE;
            res_valid <= 1'b0;
        end
        else
        begin
            if (push)
                q_wr_reg <= !q_wr_reg;
            if (pop)
                q_rd_reg <= !q_rd_reg;
            q_cnt_reg <= q_cnt_reg + {1'b0, push} - {1'b0, pop};
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                        state_reg <= (head.dsq == '0) ? ST_OUT : ST_DIV;
                    res_valid <= 1'b0;
                end
                ST_DIV:
                    if (step_reg == 6'd0)
                        state_reg <= ST_SQRT;
                ST_SQRT:
                    if (step_reg == 6'd0 || quo_reg >= CSQ_W'(67117056))
                        state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (!res_valid)
                        res_valid <= 1'b1;
                    else if (res_ready)
                    begin
                        res_valid <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                quo_reg <= head.best;
                d_reg <= head.dsq;
                rem_reg <= '0;
                step_reg <= 6'(CSQ_W - 1);
                idx_reg <= head.closest_index;
                root_reg <= '0;
                degenerate_ray <= head.dsq == '0;
            end
            ST_DIV:
            begin
                if (rem_sh >= {1'b0, d_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, d_reg};
                    quo_reg <= {quo_reg[CSQ_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[CSQ_W-2:0], 1'b0};
                end
                step_reg <= (step_reg == 6'd0) ? 6'd12 : step_reg - 1'b1;
            end
            ST_SQRT:
            begin
                if (quo_reg >= CSQ_W'(67117056))
                    root_reg <= DIST_MAX;
                else if (CSQ_W'(trial_sq) <= quo_reg)
                    root_reg <= trial;
                step_reg <= step_reg - 1'b1;
            end
            ST_OUT:
            begin
                closest_index <= degenerate_ray ? '0 : idx_reg;
                closest_distance <= degenerate_ray ? DIST_MAX : root_reg;
            end
            default: ;
        endcase
    end
endmodule

// ===== rtl/nearest_point_to_ray_unit.sv =====
// Top level of the nearest point to ray unit
//   channel | dir | payload
//   pnt     | in  | point_x, point_y, point_z, last_point
//   cfg     | in  | index, data (origin and direction registers)
//   res     | out | closest_index, closest_distance, degenerate_ray
// Points enter one per cycle unless the input stalls; a three-stage pipeline forms the cross product.
// A list end passes through a divide and then a square root in the back part.
// A two-entry queue lets the next list stream while a result is worked out.
// The input stalls only while a list end waits for a free queue entry.
// Reset clears the minimum, counter and queue; direction resets to 64 along z.
`timescale 1ns / 1ps
`include "nearest_point_to_ray_unit_defines.svh"
module nearest_point_to_ray_unit
    import npr_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_W
)(
    input logic clk,
    input logic rst_n,
    npr_point_if.sink pnt,
    npr_cfg_if.sink cfg,
    npr_result_if.source res
);
    logic [COORD_W-1:0] cfg_reg [6];
    logic job_valid, job_ready;
    job_t job;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++) cfg_reg[i] <= '0;
            cfg_reg[5] <= COORD_W'(64);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ORIGIN_X: cfg_reg[0] <= cfg.data;
                REG_ORIGIN_Y: cfg_reg[1] <= cfg.data;
                REG_ORIGIN_Z: cfg_reg[2] <= cfg.data;
                REG_DIR_X: cfg_reg[3] <= cfg.data;
                REG_DIR_Y: cfg_reg[4] <= cfg.data;
                REG_DIR_Z: cfg_reg[5] <= cfg.data;
                default: ;
            endcase
        end
    end

    npr_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(pnt.valid), .in_ready(pnt.ready),
        .point_x(pnt.point_x), .point_y(pnt.point_y), .point_z(pnt.point_z),
        .last_point(pnt.last_point), .cfg_reg(cfg_reg),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    npr_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .res_valid(res.valid), .res_ready(res.ready),
        .closest_index(res.closest_index), .closest_distance(res.closest_distance),
        .degenerate_ray(res.degenerate_ray)
    );

    `NPR_ASSERT(a_deg_max, clk, rst_n, res.valid && res.degenerate_ray |-> res.closest_distance == DIST_MAX, "degenerate distance")
    `NPR_ASSERT(a_deg_idx, clk, rst_n, res.valid && res.degenerate_ray |-> res.closest_index == '0, "degenerate index")
    `NPR_ASSERT_HOLD(a_res_hold, clk, rst_n, res.valid, res.ready, res.closest_index, "result moved")
endmodule

// ===== dv/npr_tb_if.sv =====
// Item types for the testbench
`timescale 1ns / 1ps
package npr_tb_types;
    import npr_pkg::*;
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               last;
    } point_t;
    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [DIST_W-1:0] distance;
        logic              degen;
    } nearest_t;
    typedef struct packed {
        point_t   pt;
        logic     check;
        nearest_t want;
    } row_t;
endpackage

// ===== dv/tb_nearest_point_to_ray_unit.sv =====
// Self-checking testbench for the nearest point to ray unit
`timescale 1ns / 1ps
module tb_nearest_point_to_ray_unit;
    import npr_pkg::*;
    import npr_tb_types::*;

    localparam int LIMIT = 2000000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    npr_point_if  pnt();
    npr_cfg_if    cfg();
    npr_result_if res();

    nearest_point_to_ray_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .pnt   (pnt),
        .cfg   (cfg),
        .res   (res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic signed [COORD_W-1:0] origin [3];
    logic signed [COORD_W-1:0] dirv [3];
    logic [63:0] min_cross_sq;
    logic [IDX_W-1:0] min_pos;
    logic [IDX_W-1:0] next_pos;

    nearest_t pending_nearest [$];
    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int results_seen;
    int cycles;
    bit failed;

    function automatic logic [63:0] root13(input logic [63:0] q);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        if (q >= 64'd8192 * 64'd8192)
            return 64'd8191;
        for (int b = 12; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= q)
                r = t;
        end
        return r;
    endfunction

    task automatic track_point(input point_t p);
        longint px, py, pz, dx, dy, dz, cx, cy, cz, dsq;
        logic [63:0] c;
        nearest_t n;
        px = longint'($signed(p.x)) - longint'(origin[0]);
        py = longint'($signed(p.y)) - longint'(origin[1]);
        pz = longint'($signed(p.z)) - longint'(origin[2]);
        dx = dirv[0];
        dy = dirv[1];
        dz = dirv[2];
        cx = py * dz - pz * dy;
        cy = pz * dx - px * dz;
        cz = px * dy - py * dx;
        c = cx * cx + cy * cy + cz * cz;
        dsq = dx * dx + dy * dy + dz * dz;
        if (c < min_cross_sq)
        begin
            min_cross_sq = c;
            min_pos = next_pos;
        end
        next_pos = next_pos + 1'b1;
        if (p.last)
        begin
            if (dsq == 0)
            begin
                n.index = '0;
                n.distance = DIST_MAX;
                n.degen = 1'b1;
            end
            else
            begin
                n.index = min_pos;
                n.distance = DIST_W'(root13(min_cross_sq / 64'(dsq)));
                n.degen = 1'b0;
            end
            pending_nearest.push_back(n);
            min_cross_sq = 64'h00FF_FFFF_FFFF_FFFF;
            min_pos = '0;
            next_pos = '0;
        end
    endtask

    task automatic check_typed(input nearest_t want);
        nearest_t got;
        got = pending_nearest[$];
        if (got !== want)
        begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10)
                $display("table row: exp idx %0d dist %0d deg %0b, got %0d %0d %0b",
                    want.index, want.distance, want.degen, got.index, got.distance,
                    got.degen);
        end
    endtask

    task automatic send_point(input point_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pnt.valid <= 1'b0;
            @(negedge clk);
        end
        pnt.valid <= 1'b1;
        pnt.point_x <= p.x;
        pnt.point_y <= p.y;
        pnt.point_z <= p.z;
        pnt.last_point <= p.last;
        @(posedge clk);
        while (!pnt.ready)
            @(posedge clk);
        track_point(p);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [11:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            REG_ORIGIN_X: origin[0] = val;
            REG_ORIGIN_Y: origin[1] = val;
            REG_ORIGIN_Z: origin[2] = val;
            REG_DIR_X:    dirv[0] = val;
            REG_DIR_Y:    dirv[1] = val;
            REG_DIR_Z:    dirv[2] = val;
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        pnt.valid <= 1'b0;
        while (pending_nearest.size() != 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    task automatic set_ray(input logic [11:0] o[3], input logic [11:0] d[3]);
        drain();
        write_reg(REG_ORIGIN_X, o[0]);
        write_reg(REG_ORIGIN_Y, o[1]);
        write_reg(REG_ORIGIN_Z, o[2]);
        write_reg(REG_DIR_X, d[0]);
        write_reg(REG_DIR_Y, d[1]);
        write_reg(REG_DIR_Z, d[2]);
    endtask

    function automatic logic [11:0] rand_coord();
        case ($urandom_range(5))
            0: return 12'h800;
            1: return 12'h7FF;
            2: return 12'($urandom_range(64) - 32);
            default: return 12'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        nearest_t want;
        if (rst_n && res.valid && res.ready)
        begin
            results_seen++;
            if (pending_nearest.size() == 0)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result index %0d", res.closest_index);
            end
            else
            begin
                want = pending_nearest.pop_front();
                if (res.closest_index !== want.index
                    || res.closest_distance !== want.distance
                    || res.degenerate_ray !== want.degen)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp idx %0d dist %0d deg %0b, got %0d %0d %0b",
                            want.index, want.distance, want.degen, res.closest_index,
                            res.closest_distance, res.degenerate_ray);
                end
            end
        end
    end

    always @(negedge clk)
        res.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    row_t directed [20] = '{
        '{'{12'h000, 12'h000, 12'h000, 1'b1}, 1'b1, '{16'd0, 13'd0, 1'b0}},
        '{'{12'h7FF, 12'h7FF, 12'h7FF, 1'b0}, 1'b0, '0},
        '{'{12'h800, 12'h800, 12'h800, 1'b1}, 1'b1, '{16'd0, 13'd2894, 1'b0}},
        '{'{12'h040, 12'h000, 12'h000, 1'b0}, 1'b0, '0},
        '{'{12'h040, 12'h000, 12'h100, 1'b0}, 1'b0, '0},
        '{'{12'h000, 12'h040, 12'h000, 1'b1}, 1'b0, '0},
        '{'{12'h7FF, 12'h800, 12'h000, 1'b1}, 1'b1, '{16'd0, 13'd2895, 1'b0}},
        '{'{12'h800, 12'h7FF, 12'h7FF, 1'b0}, 1'b0, '0},
        '{'{12'h001, 12'hFFF, 12'h555, 1'b0}, 1'b0, '0},
        '{'{12'hAAA, 12'h555, 12'hAAA, 1'b1}, 1'b0, '0},
        '{'{12'h010, 12'h010, 12'h000, 1'b0}, 1'b0, '0},
        '{'{12'h010, 12'h010, 12'h7FF, 1'b1}, 1'b0, '0},
        '{'{12'h7FF, 12'h7FF, 12'h000, 1'b1}, 1'b1, '{16'd0, 13'd2894, 1'b0}},
        '{'{12'h800, 12'h7FF, 12'h000, 1'b1}, 1'b0, '0},
        '{'{12'h123, 12'h456, 12'h789, 1'b0}, 1'b0, '0},
        '{'{12'hFED, 12'hCBA, 12'h987, 1'b1}, 1'b0, '0},
        '{'{12'h000, 12'h001, 12'h000, 1'b0}, 1'b0, '0},
        '{'{12'h001, 12'h000, 12'h000, 1'b0}, 1'b0, '0},
        '{'{12'h000, 12'h000, 12'h001, 1'b1}, 1'b0, '0},
        '{'{12'hFFF, 12'hFFF, 12'hFFF, 1'b1}, 1'b0, '0}
    };

    initial
    begin
        logic [11:0] o[3];
        logic [11:0] d[3];
        int n;
        int lists;
        int list_len;
        point_t p;
        pnt.valid = 1'b0;
        pnt.point_x = '0;
        pnt.point_y = '0;
        pnt.point_z = '0;
        pnt.last_point = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        origin = '{default: '0};
        dirv = '{12'sd0, 12'sd0, 12'sd64};
        min_cross_sq = 64'h00FF_FFFF_FFFF_FFFF;
        min_pos = '0;
        next_pos = '0;
        mismatches = 0;
        results_seen = 0;
        cycles = 0;
        failed = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // default ray through the origin along z: distance of (0,0,0) is zero
        pending_nearest.delete();
        for (int i = 0; i < 20; i++)
        begin
            send_point(directed[i].pt);
            if (directed[i].check)
                check_typed(directed[i].want);
        end

        o = '{12'h000, 12'h000, 12'h000};
        d = '{12'h000, 12'h000, 12'h000};
        set_ray(o, d);
        send_point('{12'h7FF, 12'h000, 12'h800, 1'b1});
        check_typed('{16'd0, DIST_MAX, 1'b1});
        o = '{12'h7FF, 12'h800, 12'h7FF};
        d = '{12'h800, 12'h800, 12'h800};
        set_ray(o, d);
        send_point('{12'h800, 12'h7FF, 12'h800, 1'b0});
        send_point('{12'h7FF, 12'h800, 12'h7FF, 1'b1});
        drain();
        write_reg(REG_SPARE_LO, 12'hFFF);
        write_reg(REG_SPARE_HI, 12'h001);

        n = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 66 : 0;
            recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 11 : 0;
            for (lists = 0; lists < 4; lists++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    o[k] = ($urandom_range(3) == 0) ? rand_coord() : 12'($urandom_range(256) - 128);
                    d[k] = rand_coord();
                end
                if ($urandom_range(9) == 0)
                    d = '{12'h000, 12'h000, 12'h000};
                set_ray(o, d);
                for (int m = 0; m < 125; m += list_len)
                begin
                    list_len = $urandom_range(12, 1);
                    for (int j = 0; j < list_len; j++)
                    begin
                        p.x = rand_coord();
                        p.y = rand_coord();
                        p.z = rand_coord();
                        if ($urandom_range(7) == 0 && j > 0)
                            p = '{p.x, p.y, p.z, 1'b0};
                        p.last = (j == list_len - 1);
                        send_point(p);
                        n++;
                    end
                end
            end
        end

        drain();
        $display("%0d random points in lists, %0d results checked, %0d mismatches",
            n, results_seen, mismatches);
        if (!failed && pending_nearest.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/npr_pkg.sv
rtl/npr_if.sv
rtl/npr_front.sv
rtl/npr_back.sv
rtl/nearest_point_to_ray_unit.sv
dv/npr_tb_if.sv
dv/tb_nearest_point_to_ray_unit.sv
